@@ hdl/bmf3_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and register codes of the 3x3 box mean filter.
package bmf3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int LANE_W        = 8;
    localparam int LANES         = 3;
    localparam int PIX_W         = LANES * LANE_W;
    localparam int WIN           = 3;
    localparam int WIN_CELLS     = WIN * WIN;
    localparam int CFG_W         = 12;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int REG_SEL_BIT   = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Register indexes, selected by paddr[REG_SEL_BIT].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Operation codes of an input beat.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef t_pixel [WIN_CELLS-1:0] t_window;

    // Border flags of the result position and the end-of-frame mark.
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_emit_meta;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PRE,
        FS_UPDATE
    } t_fstate;

endpackage

@@ hdl/bmf3_pix_if.sv @@
`timescale 1ns / 1ps
// Input channel: operation code and the three byte lanes of one pixel.
interface bmf3_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [bmf3_pkg::LANE_W-1:0] lane0_in;
    logic [bmf3_pkg::LANE_W-1:0] lane1_in;
    logic [bmf3_pkg::LANE_W-1:0] lane2_in;

    modport source (
        output valid,
        output operation,
        output lane0_in,
        output lane1_in,
        output lane2_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  lane0_in,
        input  lane1_in,
        input  lane2_in,
        output ready
    );
endinterface

@@ hdl/bmf3_res_if.sv @@
`timescale 1ns / 1ps
// Result channel: three filtered byte lanes and the end-of-frame flag.
interface bmf3_res_if;
    logic                        valid;
    logic                        ready;
    logic [bmf3_pkg::LANE_W-1:0] lane0_out;
    logic [bmf3_pkg::LANE_W-1:0] lane1_out;
    logic [bmf3_pkg::LANE_W-1:0] lane2_out;
    logic                        frame_end;

    modport source (
        output valid,
        output lane0_out,
        output lane1_out,
        output lane2_out,
        output frame_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  lane0_out,
        input  lane1_out,
        input  lane2_out,
        input  frame_end,
        output ready
    );
endinterface

@@ hdl/bmf3_line_store.sv @@
`timescale 1ns / 1ps
// Row store: upper and middle row pixel of each column, one write and one read port.
module bmf3_line_store #(
    parameter int DEPTH = bmf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [2*bmf3_pkg::PIX_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [2*bmf3_pkg::PIX_W-1:0]  o_rdata
);

    logic [2*bmf3_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*bmf3_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bmf3_mean.sv @@
`timescale 1ns / 1ps
// Window averaging pipeline: masked lane sums, then division by the cell count.
module bmf3_mean (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_win_vld,
    output logic                 o_win_take,
    input  bmf3_pkg::t_window    i_window,
    input  bmf3_pkg::t_emit_meta i_meta,
    bmf3_res_if.source           o_res
);

    localparam int LANE_W = bmf3_pkg::LANE_W;
    localparam int LANES  = bmf3_pkg::LANES;
    localparam int WIN    = bmf3_pkg::WIN;
    localparam int CELLS  = bmf3_pkg::WIN_CELLS;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int PROD_W = 2 * SUM_W;
    // Reciprocals rounded up; exact for every sum below 2^SUM_W.
    localparam logic [SUM_W-1:0] RECIP_3 = 12'd2731;
    localparam logic [SUM_W-1:0] RECIP_9 = 12'd3641;
    localparam int SHIFT_3 = 13;
    localparam int SHIFT_6 = 14;
    localparam int SHIFT_9 = 15;

    logic [WIN-1:0]    row_ok;
    logic [WIN-1:0]    col_ok;
    logic [1:0]        nr;
    logic [1:0]        nc;
    logic [SUM_W-1:0]  term  [LANES][CELLS];
    logic [SUM_W-1:0]  n_sum [LANES];
    logic [SUM_W-1:0]  r_sum [LANES];
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_s_vld;
    logic              r_s_last;
    logic [SUM_W-1:0]  recip;
    logic [PROD_W-1:0] prod  [LANES];
    logic [SUM_W-1:0]  quo   [LANES];
    logic [LANE_W-1:0] n_lane [LANES];
    logic [LANE_W-1:0] r_lane [LANES];
    logic              r_o_vld;
    logic              r_o_last;
    logic              o_take;

    assign o_take     = !r_o_vld || o_res.ready;
    assign o_win_take = !r_s_vld || o_take;

    // Sum stage: only cells inside the image contribute.
    always_comb begin
        row_ok = {i_meta.bot_ok, 1'b1, i_meta.top_ok};
        col_ok = {i_meta.right_ok, 1'b1, i_meta.left_ok};
        nr     = 2'd1 + 2'(i_meta.top_ok) + 2'(i_meta.bot_ok);
        nc     = 2'd1 + 2'(i_meta.left_ok) + 2'(i_meta.right_ok);
        n_cnt  = CNT_W'(nr) * CNT_W'(nc);
        for (int l = 0; l < LANES; l++) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    term[l][r*WIN+c] = (row_ok[r] && col_ok[c])
                        ? SUM_W'(i_window[r*WIN+c][l*LANE_W +: LANE_W]) : '0;
                end
            end
            n_sum[l] = (term[l][0] + term[l][1] + term[l][2])
                     + (term[l][3] + term[l][4] + term[l][5])
                     + (term[l][6] + term[l][7] + term[l][8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (o_win_take) begin
            r_s_vld <= i_win_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_win_take && i_win_vld) begin
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_s_last <= i_meta.last;
        end
    end

    // Divide stage: the count is 1, 2, 3, 4, 6 or 9.
    always_comb begin
        recip = (r_cnt == 4'd9) ? RECIP_9 : RECIP_3;
        for (int l = 0; l < LANES; l++) begin
            prod[l] = PROD_W'(r_sum[l]) * PROD_W'(recip);
            case (r_cnt)
                4'd1:    quo[l] = r_sum[l];
                4'd2:    quo[l] = r_sum[l] >> 1;
                4'd3:    quo[l] = SUM_W'(prod[l] >> SHIFT_3);
                4'd4:    quo[l] = r_sum[l] >> 2;
                4'd6:    quo[l] = SUM_W'(prod[l] >> SHIFT_6);
                default: quo[l] = SUM_W'(prod[l] >> SHIFT_9);
            endcase
            n_lane[l] = quo[l][LANE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_take) begin
            r_o_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && r_s_vld) begin
            r_lane   <= n_lane;
            r_o_last <= r_s_last;
        end
    end

    assign o_res.valid     = r_o_vld;
    assign o_res.lane0_out = r_lane[0];
    assign o_res.lane1_out = r_lane[1];
    assign o_res.lane2_out = r_lane[2];
    assign o_res.frame_end = r_o_last;

endmodule

@@ hdl/box_mean_filter_3x3_rgb.sv @@
`timescale 1ns / 1ps
// 3x3 box mean filter over a raster stream of 24-bit pixels.
//
// i_pix carries beats of a pixel (operation 0) or a drain (operation 1). o_res carries
// one filtered pixel per beat; frame_end marks the frame's last result. The result of a
// pixel comes out once image_width+1 further pixels have arrived; after the last pixel,
// each drain beat pushes out one pending result.
// A pixel or an active drain reads the row store entry of its column in the accept
// cycle, and a pixel writes it back in the next one; no beat is taken until the update
// state ends. The first drain of a one-row frame reads the store twice, via the pre
// state; a drain outside the drain phase gives nothing. Results pass the window slot,
// sum stage and output register; a stalled o_res fills all three, then i_pix.ready drops.
// Configuration goes through the APB port (image_width at 0x0, image_height at 0x4)
// and restarts the frame; write it only while the block is idle.
// Reset sets 640 x 480, clears the position counters and the window and leaves the row
// store contents undefined; every entry is written before a result depends on it, so
// the block needs no clearing pass and takes beats right after reset.
module box_mean_filter_3x3_rgb #(
    parameter int MAX_WIDTH = bmf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bmf3_pix_if.sink                        i_pix,
    bmf3_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmf3_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bmf3_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bmf3_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = bmf3_pkg::CFG_W;
    localparam int PIX_W = bmf3_pkg::PIX_W;
    localparam int WIN   = bmf3_pkg::WIN;
    localparam int SEL   = bmf3_pkg::REG_SEL_BIT;

    logic [HW-1:0]            r_width;
    logic [HW-1:0]            r_height;
    logic                     cfg_wr;
    logic [WW-1:0]            eff_w;
    logic [WW-1:0]            eff_w_m1;
    logic [HW-1:0]            eff_h;
    logic [HW-1:0]            eff_h_m1;

    logic [WW-1:0]            r_in_col;
    logic [HW-1:0]            r_in_row;
    logic [WW-1:0]            r_ocol;
    logic [HW-1:0]            r_orow;
    logic [WW-1:0]            n_in_col;
    logic [HW-1:0]            n_in_row;
    logic [WW-1:0]            n_ocol;
    logic [HW-1:0]            n_orow;

    bmf3_pkg::t_fstate        r_state;
    bmf3_pkg::t_fstate        n_state;

    logic                     acc;
    logic                     draining;
    logic                     is_pixel;
    logic                     clr;
    logic [WW-1:0]            cur_col;
    logic [HW-1:0]            cur_row;
    logic [WW-1:0]            cur_ocol;
    logic [HW-1:0]            cur_orow;
    logic                     col_last;
    logic                     ocol_last;
    logic                     out_last;
    logic [WW-1:0]            nxt_ocol;
    logic                     pix_emit;
    logic                     act;
    logic                     emit;
    logic                     pre;
    logic [CW-1:0]            rd_addr;
    bmf3_pkg::t_emit_meta     meta;

    bmf3_pkg::t_pixel         r_pix;
    logic                     r_is_pixel;
    logic                     r_emit;
    bmf3_pkg::t_emit_meta     r_meta;
    logic [CW-1:0]            r_wr_addr;
    logic [CW-1:0]            r_drain_col;

    logic                     mem_we;
    logic                     mem_re;
    logic [CW-1:0]            mem_raddr;
    logic [2*PIX_W-1:0]       mem_wdata;
    logic [2*PIX_W-1:0]       mem_rdata;
    bmf3_pkg::t_pixel         upper;
    bmf3_pkg::t_pixel         middle;
    bmf3_pkg::t_pixel         bottom;
    bmf3_pkg::t_pixel [WIN-1:0] col_in;
    logic                     win_shift;
    bmf3_pkg::t_window        r_window;
    bmf3_pkg::t_window        n_window;

    logic                     r_w_vld;
    bmf3_pkg::t_emit_meta     r_w_meta;
    logic                     win_take;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bmf3_pkg::WIDTH_RESET;
            r_height <= bmf3_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[SEL])
                bmf3_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[HW-1:0];
                bmf3_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[SEL-1:0] == '0) begin
            case (paddr[SEL])
                bmf3_pkg::REG_IMAGE_WIDTH:  prdata = bmf3_pkg::APB_DATA_W'(r_width);
                bmf3_pkg::REG_IMAGE_HEIGHT: prdata = bmf3_pkg::APB_DATA_W'(r_height);
                default:                    prdata = '0;
            endcase
        end
    end

    // Effective frame size: zero acts as one, the width is capped at the store depth.
    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        eff_h    = (r_height == '0) ? HW'(1) : r_height;
        eff_w_m1 = eff_w - WW'(1);
        eff_h_m1 = eff_h - HW'(1);
    end

    assign acc = i_pix.valid && i_pix.ready;

    // Position bookkeeping for the beat on i_pix.
    always_comb begin
        draining = (r_in_row >= eff_h);
        case (i_pix.operation)
            bmf3_pkg::OP_PIXEL: is_pixel = 1'b1;
            bmf3_pkg::OP_DRAIN: is_pixel = 1'b0;
            default:            is_pixel = 1'b0;
        endcase
        // A pixel during the drain phase drops what is pending and opens a new frame.
        clr      = is_pixel && draining;
        cur_col  = clr ? '0 : r_in_col;
        if (cur_col >= eff_w) begin
            cur_col = '0;
        end
        cur_row   = clr ? '0 : r_in_row;
        cur_ocol  = clr ? '0 : r_ocol;
        cur_orow  = clr ? '0 : r_orow;
        col_last  = (cur_col == eff_w_m1);
        ocol_last = (cur_ocol == eff_w_m1);
        out_last  = ocol_last && (cur_orow == eff_h_m1);
        nxt_ocol  = ocol_last ? '0 : cur_ocol + WW'(1);
        pix_emit  = (cur_row > HW'(1)) || ((cur_row == HW'(1)) && (cur_col != '0));
        act       = is_pixel || draining;
        emit      = is_pixel ? pix_emit : draining;
        // A one-row frame shifts column zero in once more on its first drain.
        pre       = !is_pixel && (r_in_col == '0) && (eff_h == HW'(1));

        meta.top_ok   = (cur_orow != '0);
        meta.bot_ok   = (cur_orow != eff_h_m1);
        meta.left_ok  = (cur_ocol != '0);
        meta.right_ok = !ocol_last;
        meta.last     = out_last;

        if (is_pixel) begin
            rd_addr = cur_col[CW-1:0];
        end else if (pre) begin
            rd_addr = '0;
        end else begin
            rd_addr = nxt_ocol[CW-1:0];
        end

        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        if (cfg_wr) begin
            n_in_col = '0;
            n_in_row = '0;
            n_ocol   = '0;
            n_orow   = '0;
        end else if (acc && act) begin
            if (is_pixel) begin
                n_in_col = col_last ? '0 : cur_col + WW'(1);
                n_in_row = col_last ? cur_row + HW'(1) : cur_row;
            end else begin
                n_in_col = WW'(1);
            end
            n_ocol = cur_ocol;
            n_orow = cur_orow;
            if (emit) begin
                n_ocol = nxt_ocol;
                n_orow = ocol_last ? cur_orow + HW'(1) : cur_orow;
                if (out_last) begin
                    n_in_col = '0;
                    n_in_row = '0;
                    n_ocol   = '0;
                    n_orow   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pix       <= {i_pix.lane2_in, i_pix.lane1_in, i_pix.lane0_in};
            r_is_pixel  <= is_pixel;
            r_emit      <= emit;
            r_meta      <= meta;
            r_wr_addr   <= cur_col[CW-1:0];
            r_drain_col <= nxt_ocol[CW-1:0];
        end
    end

    // Sequencer: a row store read per item, then its update; only pixels write the entry back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmf3_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bmf3_pkg::FS_IDLE: begin
                if (acc && act) begin
                    n_state = pre ? bmf3_pkg::FS_PRE : bmf3_pkg::FS_UPDATE;
                end
            end
            bmf3_pkg::FS_PRE:    n_state = bmf3_pkg::FS_UPDATE;
            bmf3_pkg::FS_UPDATE: n_state = bmf3_pkg::FS_IDLE;
            default:             n_state = bmf3_pkg::FS_IDLE;
        endcase
    end

    // The emit slot is free by the time the item reaches its update cycle.
    assign i_pix.ready = (r_state == bmf3_pkg::FS_IDLE) && (!r_w_vld || win_take);

    // Row store access.
    assign mem_re    = (acc && act) || (r_state == bmf3_pkg::FS_PRE);
    assign mem_raddr = (r_state == bmf3_pkg::FS_PRE) ? r_drain_col : rd_addr;
    assign upper     = mem_rdata[2*PIX_W-1:PIX_W];
    assign middle    = mem_rdata[PIX_W-1:0];
    assign mem_we    = (r_state == bmf3_pkg::FS_UPDATE) && r_is_pixel;
    assign mem_wdata = {middle, r_pix};

    bmf3_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Window: shift left by one column, the new column enters on the right.
    always_comb begin
        bottom    = ((r_state == bmf3_pkg::FS_UPDATE) && r_is_pixel) ? r_pix : '0;
        col_in    = {bottom, middle, upper};
        win_shift = (r_state == bmf3_pkg::FS_PRE) || (r_state == bmf3_pkg::FS_UPDATE);
        for (int r = 0; r < WIN; r++) begin
            n_window[r*WIN]     = r_window[r*WIN + 1];
            n_window[r*WIN + 1] = r_window[r*WIN + 2];
            n_window[r*WIN + 2] = col_in[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (win_shift) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if ((r_state == bmf3_pkg::FS_UPDATE) && r_emit) begin
            r_w_vld <= 1'b1;
        end else if (win_take) begin
            r_w_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bmf3_pkg::FS_UPDATE) && r_emit) begin
            r_w_meta <= r_meta;
        end
    end

    bmf3_mean u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_win_vld  (r_w_vld),
        .o_win_take (win_take),
        .i_window   (r_window),
        .i_meta     (r_w_meta),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bmf3_pkg::FS_UPDATE) && r_emit) |-> !r_w_vld)
        else $error("window result overwritten before the sum stage took it");

    a_pre_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmf3_pkg::FS_PRE) |=> (r_state == bmf3_pkg::FS_UPDATE))
        else $error("extra drain shift not followed by its update");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmf3_pkg::FS_IDLE) |-> (r_in_col <= eff_w))
        else $error("input column beyond the frame width");

    a_orow_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmf3_pkg::FS_IDLE) |-> (r_orow < eff_h))
        else $error("output row beyond the frame height");
`endif

endmodule

@@ verif/box_mean_filter_3x3_rgb_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the 3x3 box mean filter: predicted means versus the result stream.
module box_mean_filter_3x3_rgb_test;
    import bmf3_pkg::*;

    typedef struct packed {
        logic [LANE_W-1:0] lane0;
        logic [LANE_W-1:0] lane1;
        logic [LANE_W-1:0] lane2;
        logic              frame_end;
    } mean_beat_t;

    // Tracks the frame position, row stores and window, and queues the means they imply.
    class bmf3_scoreboard;
        t_pixel           upper_row [MAX_WIDTH_DEF];
        t_pixel           middle_row[MAX_WIDTH_DEF];
        t_pixel           win       [WIN_CELLS];
        int unsigned      in_col;
        int unsigned      in_row;
        int unsigned      out_pos;
        logic [CFG_W-1:0] cfg_width;
        logic [CFG_W-1:0] cfg_height;
        mean_beat_t       expected_means[$];
        int unsigned      errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            cfg_width  = WIDTH_RESET;
            cfg_height = HEIGHT_RESET;
            errors     = 0;
            restart();
        endfunction

        function int unsigned eff_width();
            if (cfg_width == 0) return 1;
            if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return cfg_width;
        endfunction

        function int unsigned eff_height();
            return (cfg_height == 0) ? 1 : cfg_height;
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
        endfunction

        function void write_reg(logic idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH) begin
                cfg_width = value[CFG_W-1:0];
            end else begin
                cfg_height = value[CFG_W-1:0];
            end
            restart();
        endfunction

        function int pending_count();
            return expected_means.size();
        endfunction

        function bit is_draining();
            return in_row >= eff_height();
        endfunction

        // Outside the store range the top and middle cells of the new column are zero.
        function void shift_column(int unsigned c, t_pixel bottom);
            t_pixel top = '0;
            t_pixel mid = '0;
            if (c < MAX_WIDTH_DEF) begin
                top = upper_row[c];
                mid = middle_row[c];
            end
            for (int r = 0; r < WIN; r++) begin
                win[r*WIN]     = win[r*WIN + 1];
                win[r*WIN + 1] = win[r*WIN + 2];
                win[r*WIN + 2] = (r == 0) ? top : ((r == 1) ? mid : bottom);
            end
        endfunction

        function void predict_mean();
            int unsigned w, h, total, ocol, orow, r0, r1, c0, c1, count;
            int unsigned sum[LANES];
            mean_beat_t  m;
            w     = eff_width();
            h     = eff_height();
            total = w * h;
            ocol  = out_pos % w;
            orow  = out_pos / w;
            r0    = (orow >= 1) ? 0 : 1;
            r1    = (orow + 1 < h) ? 2 : 1;
            c0    = (ocol >= 1) ? 0 : 1;
            c1    = (ocol + 1 < w) ? 2 : 1;
            count = (r1 - r0 + 1) * (c1 - c0 + 1);
            foreach (sum[l]) sum[l] = 0;
            for (int unsigned r = r0; r <= r1; r++) begin
                for (int unsigned c = c0; c <= c1; c++) begin
                    for (int l = 0; l < LANES; l++) begin
                        sum[l] += win[r*WIN + c][l*LANE_W +: LANE_W];
                    end
                end
            end
            m.lane0     = LANE_W'(sum[0] / count);
            m.lane1     = LANE_W'(sum[1] / count);
            m.lane2     = LANE_W'(sum[2] / count);
            m.frame_end = (out_pos + 1 >= total);
            expected_means.push_back(m);
            out_pos++;
            if (out_pos >= total) restart();
        endfunction

        // Returns 1 when the beat changes the block's state.
        function bit note_beat(logic op, logic [LANE_W-1:0] l0, l1, l2);
            int unsigned w, h, c, n;
            t_pixel      pix;
            w = eff_width();
            h = eff_height();
            if (op == OP_PIXEL) begin
                // A pixel during the drain phase drops what is pending and opens a new frame.
                if (in_row >= h) restart();
                if (in_col >= w) in_col = 0;
                pix = {l2, l1, l0};
                c   = in_col;
                n   = in_row * w + c;
                shift_column(c, pix);
                if (c < MAX_WIDTH_DEF) begin
                    upper_row[c]  = middle_row[c];
                    middle_row[c] = pix;
                end
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
                if (n >= w + 1) predict_mean();
                return 1'b1;
            end
            if (in_row < h) return 1'b0;
            // A one-row frame needs one extra window shift on its first drain.
            if (in_col == 0 && h == 1) shift_column(0, '0);
            in_col = 1;
            shift_column((out_pos + 1) % w, '0);
            predict_mean();
            return 1'b1;
        endfunction

        function void check_beat(mean_beat_t got);
            mean_beat_t want;
            if (expected_means.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result beat with nothing expected: lanes %h %h %h end %b",
                             $realtime, got.lane0, got.lane1, got.lane2, got.frame_end);
                end
                return;
            end
            want = expected_means.pop_front();
            if (want != got) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mean mismatch: expected %h %h %h end %b, got %h %h %h end %b",
                             $realtime, want.lane0, want.lane1, want.lane2, want.frame_end,
                             got.lane0, got.lane1, got.lane2, got.frame_end);
                end
            end
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bmf3_pix_if pix ();
    bmf3_res_if res ();

    box_mean_filter_3x3_rgb DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bmf3_scoreboard sb;
    int             in_gap_max  = 12;
    int             out_gap_max = 12;
    int             long_hold   = 0;
    int unsigned    beats_counted;

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
            sb.check_beat({res.lane0_out, res.lane1_out, res.lane2_out, res.frame_end});
        end
    end

    // Result side: random stalls per beat, and a long hold-off when one is requested.
    initial begin
        int stall;
        res.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, out_gap_max);
            if (long_hold > 0) begin
                stall     = long_hold;
                long_hold = 0;
            end
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (res.valid !== 1'b1);
        end
    end

    function automatic logic [LANE_W-1:0] random_lane();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return LANE_W'($urandom_range(0, 255));
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic op, input logic [LANE_W-1:0] l0, l1, l2);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.operation <= op;
        pix.lane0_in  <= l0;
        pix.lane1_in  <= l1;
        pix.lane2_in  <= l2;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        if (sb.note_beat(op, l0, l1, l2)) beats_counted++;
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_beat(OP_PIXEL, random_lane(), random_lane(), random_lane());
    endtask

    task automatic send_drains(input int unsigned count);
        repeat (count) send_beat(OP_DRAIN, random_lane(), random_lane(), random_lane());
    endtask

    task automatic drain_frame();
        while (sb.is_draining()) send_drains(1);
    endtask

    // Quiet the input and let every expected beat and any silent drain finish.
    task automatic settle();
        pix.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr              = '0;
        addr[REG_SEL_BIT] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        settle();
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic random_phase();
        int unsigned w, h, frames, kind, total;
        logic [APB_DATA_W-1:0] junk;
        int pick;
        pick = $urandom_range(0, 9);
        w = (pick < 6) ? $urandom_range(1, 6) : ((pick < 9) ? $urandom_range(7, 24)
                                                             : $urandom_range(25, 70));
        h = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        if ($urandom_range(0, 19) == 0) w = 0;
        if ($urandom_range(0, 19) == 0) h = 0;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_F000) : '0;
        settle();
        pick = $urandom_range(0, 3);
        if (pick != 1) apb_write(REG_IMAGE_WIDTH, junk | w);
        if (pick != 2) apb_write(REG_IMAGE_HEIGHT, junk | h);
        pick = $urandom_range(0, 2);
        in_gap_max  = (pick == 0) ? 0 : ((pick == 1) ? 2 : 12);
        pick = $urandom_range(0, 2);
        out_gap_max = (pick == 0) ? 0 : ((pick == 1) ? 2 : 12);
        frames = $urandom_range(1, 3);
        repeat (frames) begin
            total = sb.eff_width() * sb.eff_height();
            kind  = $urandom_range(0, 9);
            if (kind <= 6) begin
                for (int unsigned i = 0; i < total; i++) begin
                    // Occasional stray drain mid-frame, which the block ignores.
                    if ($urandom_range(0, 19) == 0) send_drains(1);
                    send_pixels(1);
                end
                drain_frame();
                if ($urandom_range(0, 3) == 0) send_drains($urandom_range(1, 2));
            end else if (kind == 7) begin
                send_pixels($urandom_range(1, total));
                send_drains($urandom_range(0, sb.eff_width() + 1));
            end else begin
                repeat (2 * total) begin
                    send_beat(($urandom_range(0, 9) < 3) ? OP_DRAIN : OP_PIXEL,
                              random_lane(), random_lane(), random_lane());
                end
            end
        end
    endtask

    initial begin
        sb = new();
        pix.valid     <= 1'b0;
        pix.operation <= OP_PIXEL;
        pix.lane0_in  <= '0;
        pix.lane1_in  <= '0;
        pix.lane2_in  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size: a pixel, then a drain that finds no drain phase.
        send_beat(OP_PIXEL, 8'h12, 8'h34, 8'h56);
        send_drains(1);

        // Full 3x3 frame at the lane extremes, its drains and one surplus drain.
        set_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) begin
                send_beat(OP_PIXEL, 8'h00, 8'hFF, 8'h80);
            end else if (i % 3 == 0) begin
                send_beat(OP_PIXEL, 8'h00, 8'h00, 8'h00);
            end else begin
                send_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
            end
        end
        drain_frame();
        send_drains(1);

        // One-row frame.
        set_size(2, 1);
        send_pixels(2);
        drain_frame();

        // A pixel in the middle of the drain phase.
        set_size(2, 2);
        send_pixels(4);
        send_drains(1);
        send_pixels(1);

        // Receiver holds off for a long stretch while pixels keep coming.
        set_size(16, 8);
        in_gap_max  = 0;
        out_gap_max = 0;
        long_hold   = 300;
        send_pixels(16 * 8);
        drain_frame();

        // Zero size registers act as one.
        set_size(0, 0);
        in_gap_max  = 3;
        out_gap_max = 3;
        send_pixels(1);
        drain_frame();
        send_drains(1);
        send_pixels(1);
        drain_frame();

        // All-ones registers: width clamps to the store size; the frame is cut by a write.
        in_gap_max  = 1;
        out_gap_max = 1;
        settle();
        apb_write(REG_IMAGE_WIDTH, 32'hA5A5_AFFF);
        apb_write(REG_IMAGE_HEIGHT, 32'h5A5A_5FFF);
        send_pixels(MAX_WIDTH_DEF + 52);

        // Widest one-row frame.
        set_size(MAX_WIDTH_DEF, 1);
        send_pixels(MAX_WIDTH_DEF);
        drain_frame();

        beats_counted = 0;
        while (beats_counted < 1100) random_phase();

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
